// ===== src/decimal_magnitude_compare_defines.svh =====
// ----------------------------------------------------------------------------
// decimal_magnitude_compare_defines
// Assertion macros used by the decimal_magnitude_compare module.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_MAGNITUDE_COMPARE_DEFINES_SVH
`define DECIMAL_MAGNITUDE_COMPARE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DMC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmc assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define DMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmc assertion failed: next-cycle implication");

`endif

// ===== src/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and constants for the decimal magnitude compare block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

   // Default sizes of the mantissa and the power-of-ten scale
   localparam int MANTISSA_BITS_DEFAULT = 96;
   localparam int SCALE_BITS_DEFAULT    = 5;

   // Fixed widths of the transaction fields
   localparam int MANT_LO_WIDTH = 64;
   localparam int MANT_HI_WIDTH = 32;
   localparam int MANT_IN_WIDTH = MANT_LO_WIDTH + MANT_HI_WIDTH;
   localparam int SCALE_WIDTH   = 5;

   // Input transaction
   typedef struct packed {
      logic [MANT_LO_WIDTH-1:0] a_mant_lo;
      logic [MANT_HI_WIDTH-1:0] a_mant_hi;
      logic [SCALE_WIDTH-1:0]   a_scale;
      logic [MANT_LO_WIDTH-1:0] b_mant_lo;
      logic [MANT_HI_WIDTH-1:0] b_mant_hi;
      logic [SCALE_WIDTH-1:0]   b_scale;
   } dmc_req_type;

   // Result transaction
   typedef struct packed {
      logic is_less;
      logic is_greater;
   } dmc_rsp_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;
      logic step;
   } dmc_ctrl_type;

   // Datapath status back to the sequencer
   typedef struct packed {
      logic steps_zero;
      logic over;
      logic scale_b;
      logic a_lt_b;
      logic a_gt_b;
   } dmc_stat_type;

   // Sequencer states
   typedef enum logic {
      DMC_IDLE,
      DMC_ALIGN
   } dmc_state_type;

endpackage : dmc_pkg

`default_nettype wire

// ===== src/dmc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmc_datapath
// Operand registers, shared multiply-by-ten unit and final magnitude compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_datapath #(
   parameter int MANTISSA_BITS = dmc_pkg::MANTISSA_BITS_DEFAULT,
   parameter int SCALE_BITS    = dmc_pkg::SCALE_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire dmc_pkg::dmc_req_type req,
   input  wire dmc_pkg::dmc_ctrl_type ctrl,
   output      dmc_pkg::dmc_stat_type stat
);
   import dmc_pkg::*;

   localparam int ExtBits = MANTISSA_BITS + MANT_IN_WIDTH;

   logic [MANTISSA_BITS-1:0]   a_mant_ff, a_mant_in;
   logic [MANTISSA_BITS-1:0]   b_mant_ff, b_mant_in;
   logic [SCALE_BITS-1:0]      steps_ff, steps_in;
   logic                       scale_b_ff, scale_b_in;

   logic [ExtBits-1:0]         a_ext, b_ext;
   logic [SCALE_BITS+SCALE_WIDTH-1:0] a_scale_ext, b_scale_ext;
   logic [SCALE_BITS-1:0]      sa, sb;
   logic [MANTISSA_BITS-1:0]   mul_src;
   logic [MANTISSA_BITS+3:0]   mul_src_ext, product;

   // Drop mantissa and scale bits beyond the configured widths
   assign a_ext       = ExtBits'({req.a_mant_hi, req.a_mant_lo});
   assign b_ext       = ExtBits'({req.b_mant_hi, req.b_mant_lo});
   assign a_scale_ext = (SCALE_BITS+SCALE_WIDTH)'(req.a_scale);
   assign b_scale_ext = (SCALE_BITS+SCALE_WIDTH)'(req.b_scale);
   assign sa          = a_scale_ext[SCALE_BITS-1:0];
   assign sb          = b_scale_ext[SCALE_BITS-1:0];

   // Shared multiply-by-ten: x*8 + x*2 on the operand with the smaller scale
   assign mul_src     = scale_b_ff ? b_mant_ff : a_mant_ff;
   assign mul_src_ext = (MANTISSA_BITS+4)'(mul_src);
   assign product     = (mul_src_ext << 3) + (mul_src_ext << 1);

   // Load operands, or advance the scaled operand by one decade
   always_comb begin
      a_mant_in  = a_mant_ff;
      b_mant_in  = b_mant_ff;
      steps_in   = steps_ff;
      scale_b_in = scale_b_ff;
      if (ctrl.load) begin
         a_mant_in  = a_ext[MANTISSA_BITS-1:0];
         b_mant_in  = b_ext[MANTISSA_BITS-1:0];
         scale_b_in = (sa > sb);
         steps_in   = (sa > sb) ? (sa - sb) : (sb - sa);
      end else if (ctrl.step) begin
         if (scale_b_ff) begin
            b_mant_in = product[MANTISSA_BITS-1:0];
         end else begin
            a_mant_in = product[MANTISSA_BITS-1:0];
         end
         steps_in = steps_ff - SCALE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      a_mant_ff  <= a_mant_in;
      b_mant_ff  <= b_mant_in;
      steps_ff   <= steps_in;
      scale_b_ff <= scale_b_in;
   end

   // Report alignment progress, overflow of the next step and the compare
   always_comb begin
      stat.steps_zero = (steps_ff == '0);
      stat.over       = |product[MANTISSA_BITS+3:MANTISSA_BITS];
      stat.scale_b    = scale_b_ff;
      stat.a_lt_b     = (a_mant_ff < b_mant_ff);
      stat.a_gt_b     = (a_mant_ff > b_mant_ff);
   end

endmodule : dmc_datapath

`default_nettype wire

// ===== src/decimal_magnitude_compare.sv =====
// ----------------------------------------------------------------------------
// decimal_magnitude_compare
// Magnitude compare of two scaled decimal numbers (mantissa / 10^scale).
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The operand with
// the smaller scale is multiplied by ten in a single shared multiply-by-ten
// unit, one decade per clock, until the scales match; the aligned mantissas
// are then compared and the result registered. The rsp_valid strobe follows
// once the scales match, or earlier when the scaled operand overflows the
// mantissa width, in which case that operand is reported as the larger.
// Busy drops in the same cycle as the strobe, so the next transaction may
// start then. The result is flagged valid by rsp_valid for exactly one
// cycle and cannot be held off by the receiver; it must be captured on that
// edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_magnitude_compare_defines.svh"

module decimal_magnitude_compare #(
   parameter int MANTISSA_BITS = dmc_pkg::MANTISSA_BITS_DEFAULT,
   parameter int SCALE_BITS    = dmc_pkg::SCALE_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire dmc_pkg::dmc_req_type req_data,
   output      logic                 rsp_valid,
   output      dmc_pkg::dmc_rsp_type rsp_data
);
   import dmc_pkg::*;

   dmc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dmc_rsp_type   rsp_data_ff, rsp_data_in;
   dmc_ctrl_type  ctrl;
   dmc_stat_type  stat;

   dmc_datapath #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .SCALE_BITS    (SCALE_BITS)
   ) u_datapath (
      .clock (clock),
      .req   (req_data),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   // Hold sequencer state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DMC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Sequence load, alignment steps and the final decision
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ctrl.load    = 1'b0;
      ctrl.step    = 1'b0;
      case (state_ff)
         DMC_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = DMC_ALIGN;
            end
         end
         DMC_ALIGN: begin
            if (stat.steps_zero) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.is_less    = stat.a_lt_b;
               rsp_data_in.is_greater = stat.a_gt_b;
               state_in               = DMC_IDLE;
            end else if (stat.over) begin
               // Scaled operand left the mantissa range: it is the larger
               rsp_valid_in           = 1'b1;
               rsp_data_in.is_less    = stat.scale_b;
               rsp_data_in.is_greater = !stat.scale_b;
               state_in               = DMC_IDLE;
            end else begin
               ctrl.step = 1'b1;
            end
         end
         default: begin
            state_in = DMC_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != DMC_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Accepted transaction always enters alignment
   `DMC_ASSERT_NEXT(a_accept_aligns, clock, reset, start && !busy, state_ff == DMC_ALIGN)
   // Finished alignment always produces a strobe next cycle
   `DMC_ASSERT_NEXT(a_done_strobes, clock, reset,
      state_ff == DMC_ALIGN && stat.steps_zero, rsp_valid)
   // A strobe never carries both flags
   `DMC_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid,
      !(rsp_data.is_less && rsp_data.is_greater))

endmodule : decimal_magnitude_compare

`default_nettype wire
